// ===== hw/rtl/cbsq_pkg.sv =====
// Shared constants and types for the checkerboard square counter.
package cbsq_pkg;

  localparam int MAX_COLS = 4096;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int WIDTH_W  = 13;
  localparam int CELL_W   = 8;
  localparam int RUN_W    = 13;
  localparam int TOTAL_W  = 48;

  localparam logic [RUN_W-1:0]   RUN_MAX   = {RUN_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [WIDTH_W-1:0] WIDTH_RST = WIDTH_W'(MAX_COLS);

  // One line buffer entry: the row-below data of one column.
  typedef struct packed {
    logic [CELL_W-1:0] cell_val;
    logic [RUN_W-1:0]  down_run;
    logic [RUN_W-1:0]  size;
  } row_entry_t;

endpackage

// ===== hw/rtl/cbsq_in_if.sv =====
// Input channel: one grid cell per beat.
interface cbsq_in_if;
  import cbsq_pkg::*;

  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_value;
  logic              end_of_grid;

  modport source (output valid, output cell_value, output end_of_grid, input ready);
  modport sink   (input valid, input cell_value, input end_of_grid, output ready);
endinterface

// ===== hw/rtl/cbsq_out_if.sv =====
// Result channel: square size and running total per beat.
interface cbsq_out_if;
  import cbsq_pkg::*;

  logic               valid;
  logic               ready;
  logic [RUN_W-1:0]   square_size;
  logic [TOTAL_W-1:0] running_total;
  logic               total_done;

  modport source (output valid, output square_size, output running_total,
                  output total_done, input ready);
  modport sink   (input valid, input square_size, input running_total,
                  input total_done, output ready);
endinterface

// ===== hw/rtl/cbsq_cfg_if.sv =====
// Configuration write channel: row width.
interface cbsq_cfg_if;
  import cbsq_pkg::*;

  logic               valid;
  logic               ready;
  logic [WIDTH_W-1:0] row_width;

  modport source (output valid, output row_width, input ready);
  modport sink   (input valid, input row_width, output ready);
endinterface

// ===== hw/rtl/checkerboard_square_counter.sv =====
// Checkerboard square counter: one cell in per clock unless the output
// stalls, one result out per cell.
// Cells arrive last row first, each row right to left. For every cell the
// block gives the side of the largest checkerboard square with its top-left
// corner there, plus a running total of sizes saturating at 2^48-1;
// total_done marks the beat of the cell flagged end_of_grid, after which a
// new grid starts. The row width (1..4096; 0 acts as 1, larger values as
// 4096), reset value 4096, must be written on the cfg channel only while
// the block is idle; the block itself does not enforce this. Throughput is
// one cell per clock while the output is not stalled. The line buffer read
// at acceptance fills stage 1; the compute stage writes back into it and
// loads the output register. The line buffer is a single 4096 x 34 bit
// memory, one read and one write port; a same-address read and write in one
// clock (narrow rows) is forwarded. No clearing pass is needed after reset.
module checkerboard_square_counter (
  input  logic            clk,
  input  logic            rst_n,
  cbsq_in_if.sink         in_chan,
  cbsq_out_if.source      out_chan,
  cbsq_cfg_if.sink        cfg_chan
);
  import cbsq_pkg::*;

  // ---------------- configuration ----------------
  logic [WIDTH_W-1:0] row_width_r;
  logic [WIDTH_W-1:0] width_eff;

  assign cfg_chan.ready = 1'b1;

  always_comb begin
    if (row_width_r == '0) begin
      width_eff = WIDTH_W'(1);
    end else if (row_width_r > WIDTH_RST) begin
      width_eff = WIDTH_RST;
    end else begin
      width_eff = row_width_r;
    end
  end

  // ---------------- handshakes ----------------
  logic s1_valid_r;
  logic s1_adv;
  logic in_acc;
  logic out_valid_r;

  assign s1_adv         = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !s1_valid_r || s1_adv;
  assign in_acc         = in_chan.valid && in_chan.ready;

  // ---------------- column tracking (at acceptance) ----------------
  logic [COL_W-1:0]   col_pos_r, col_pos_nxt;
  logic               first_row_r, first_row_nxt;
  logic [COL_W-1:0]   pos;
  logic [WIDTH_W-1:0] pos_inc;

  always_comb begin
    if ({1'b0, col_pos_r} >= width_eff) begin
      pos = COL_W'(width_eff - WIDTH_W'(1));
    end else begin
      pos = col_pos_r;
    end
    pos_inc       = {1'b0, pos} + WIDTH_W'(1);
    col_pos_nxt   = col_pos_r;
    first_row_nxt = first_row_r;
    if (in_acc) begin
      if (in_chan.end_of_grid) begin
        col_pos_nxt   = '0;
        first_row_nxt = 1'b1;
      end else if (pos_inc >= width_eff) begin
        col_pos_nxt   = '0;
        first_row_nxt = 1'b0;
      end else begin
        col_pos_nxt   = pos_inc[COL_W-1:0];
      end
    end
  end

  // ---------------- stage 1 registers ----------------
  logic [CELL_W-1:0] s1_cell_r;
  logic              s1_last_r;
  logic [COL_W-1:0]  s1_pos_r;
  logic              s1_last_col_r;
  logic              s1_last_row_r;

  // ---------------- line buffer ----------------
  row_entry_t row_mem [MAX_COLS];
  row_entry_t rd_r;
  row_entry_t byp_data_r;
  logic       byp_r;
  row_entry_t wr_data;
  row_entry_t below;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      row_mem[s1_pos_r] <= wr_data;
    end
    if (in_acc) begin
      rd_r       <= row_mem[pos];
      byp_r      <= s1_adv && (s1_pos_r == pos);
      byp_data_r <= wr_data;
    end
  end

  assign below = byp_r ? byp_data_r : rd_r;

  // ---------------- compute ----------------
  logic [CELL_W-1:0]  right_cell_r, right_cell_nxt;
  logic [RUN_W-1:0]   right_run_r, right_run_nxt;
  logic [CELL_W-1:0]  diag_cell_r, diag_cell_nxt;
  logic [RUN_W-1:0]   diag_size_r, diag_size_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;

  logic [RUN_W-1:0]   rr, dr, size, m_rd;
  logic [RUN_W:0]     diag_inc;
  logic [TOTAL_W:0]   sum_wide;
  logic [TOTAL_W-1:0] total_sat;

  always_comb begin
    // right run
    if (s1_last_col_r || (s1_cell_r == right_cell_r)) begin
      rr = RUN_W'(1);
    end else if (right_run_r >= RUN_MAX) begin
      rr = RUN_MAX;
    end else begin
      rr = right_run_r + RUN_W'(1);
    end
    // down run
    if (s1_last_row_r || (s1_cell_r == below.cell_val)) begin
      dr = RUN_W'(1);
    end else if (below.down_run >= RUN_MAX) begin
      dr = RUN_MAX;
    end else begin
      dr = below.down_run + RUN_W'(1);
    end
    // square size: min of both runs and diagonal + 1
    m_rd     = (rr < dr) ? rr : dr;
    diag_inc = {1'b0, diag_size_r} + (RUN_W+1)'(1);
    if (s1_last_row_r || s1_last_col_r || (s1_cell_r != diag_cell_r)) begin
      size = RUN_W'(1);
    end else if ({1'b0, m_rd} < diag_inc) begin
      size = m_rd;
    end else begin
      size = diag_inc[RUN_W-1:0];
    end

    wr_data.cell_val = s1_cell_r;
    wr_data.down_run = dr;
    wr_data.size     = size;

    // saturating total
    sum_wide  = {1'b0, total_r} + {{(TOTAL_W+1-RUN_W){1'b0}}, size};
    total_sat = sum_wide[TOTAL_W] ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];

    right_cell_nxt = right_cell_r;
    right_run_nxt  = right_run_r;
    diag_cell_nxt  = diag_cell_r;
    diag_size_nxt  = diag_size_r;
    total_nxt      = total_r;
    if (s1_adv) begin
      if (s1_last_r) begin
        // end of grid: back to fresh-grid state
        right_cell_nxt = '0;
        right_run_nxt  = '0;
        diag_cell_nxt  = '0;
        diag_size_nxt  = '0;
        total_nxt      = '0;
      end else begin
        right_cell_nxt = s1_cell_r;
        right_run_nxt  = rr;
        diag_cell_nxt  = below.cell_val;
        diag_size_nxt  = below.size;
        total_nxt      = total_sat;
      end
    end
  end

  // ---------------- output register ----------------
  logic [RUN_W-1:0]   out_size_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic               out_done_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cell_r     <= in_chan.cell_value;
      s1_last_r     <= in_chan.end_of_grid;
      s1_pos_r      <= pos;
      s1_last_col_r <= (pos == '0);
      s1_last_row_r <= first_row_r;
    end
    if (s1_adv) begin
      out_size_r  <= size;
      out_total_r <= total_sat;
      out_done_r  <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r  <= WIDTH_RST;
      col_pos_r    <= '0;
      first_row_r  <= 1'b1;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      right_cell_r <= '0;
      right_run_r  <= '0;
      diag_cell_r  <= '0;
      diag_size_r  <= '0;
      total_r      <= '0;
    end else begin
      if (cfg_chan.valid) begin
        row_width_r <= cfg_chan.row_width;
      end
      col_pos_r    <= col_pos_nxt;
      first_row_r  <= first_row_nxt;
      right_cell_r <= right_cell_nxt;
      right_run_r  <= right_run_nxt;
      diag_cell_r  <= diag_cell_nxt;
      diag_size_r  <= diag_size_nxt;
      total_r      <= total_nxt;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.square_size   = out_size_r;
  assign out_chan.running_total = out_total_r;
  assign out_chan.total_done    = out_done_r;

endmodule
